/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Operation and status codes, sequencer states and the stored entry layout.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH   = 16;
    localparam int PRIO_W      = 32;
    localparam int PAYLOAD_W   = 32;
    localparam int SEQ_W       = 32;
    localparam int CNT_OUT_W   = 5;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
        logic [SEQ_W-1:0]         seq;
    } t_entry;

endpackage

/* sv/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, FIFO among equal priorities
// Entries sit unsorted in a memory; a dequeue scans them with one shared
// priority/age comparator and moves the last entry into the freed slot.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_axis   in   priority_req[31:0], payload[63:32]       op[1:0]
//   m_axis   out  out_payload[31:0], entry_count[36:32],   out_valid[0],
//                 is_empty[37], zero[39:38]                status[2:1]
//
// Enqueue, clear and a refused dequeue go from accept straight to the result
// state. A dequeue first scans, one memory read per held entry through the
// comparator, then goes to the result state.
// s_axis_tready is high only while the sequencer is idle; a finished word
// waits in the output register, and a new word is taken meanwhile.
// Reset clears count, sequence counter and handshake state; memory is not.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // priority_req[31:0], payload[63:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_payload[31:0], entry_count[36:32],
                                        // is_empty[37], zero[39:38]
    output logic [2:0]  m_axis_tuser    // out_valid[0], status[2:1]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [SEQ_W-1:0]     r_next_seq, n_next_seq;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_best_idx, n_best_idx;
    logic signed [PRIO_W-1:0] r_best_prio, n_best_prio;
    logic [SEQ_W-1:0]     r_best_age, n_best_age;
    logic [PAYLOAD_W-1:0] r_best_payload, n_best_payload;
    logic [PAYLOAD_W-1:0] r_res_payload, n_res_payload;
    logic                 r_res_valid, n_res_valid;
    t_status              r_res_status, n_res_status;
    logic                 r_m_tvalid, n_m_tvalid;
    logic [39:0]          r_m_tdata, n_m_tdata;
    logic [2:0]           r_m_tuser, n_m_tuser;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    t_entry               mem_wd;
    logic [AW-1:0]        mem_ra;

    logic [SEQ_W-1:0]     cand_age;
    logic                 take;
    logic                 last;
    t_op                  in_op;

    assign in_op         = t_op'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_next_seq     = r_next_seq;
        n_idx          = r_idx;
        n_best_idx     = r_best_idx;
        n_best_prio    = r_best_prio;
        n_best_age     = r_best_age;
        n_best_payload = r_best_payload;
        n_res_payload  = r_res_payload;
        n_res_valid    = r_res_valid;
        n_res_status   = r_res_status;
        n_m_tvalid     = r_m_tvalid;
        n_m_tdata      = r_m_tdata;
        n_m_tuser      = r_m_tuser;
        mem_we         = 1'b0;
        mem_wa         = r_count[AW-1:0];
        mem_wd         = r_rd_data;
        mem_ra         = '0;

        cand_age = r_next_seq - r_rd_data.seq;
        take     = (r_idx == '0)
                || (r_rd_data.prio > r_best_prio)
                || ((r_rd_data.prio == r_best_prio) && (cand_age > r_best_age));
        last     = ({{(CW-AW){1'b0}}, r_idx} == (r_count - CW'(1)));

        // drop the output word once taken
        if (r_m_tvalid && m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_payload = '0;
                    n_res_valid   = 1'b0;
                    n_res_status  = STAT_OK;
                    n_state       = S_DONE;
                    case (in_op)
                        OP_ENQ: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                mem_wd.prio  = s_axis_tdata[31:0];
                                mem_wd.payload = s_axis_tdata[63:32];
                                mem_wd.seq   = r_next_seq;
                                n_next_seq   = r_next_seq + SEQ_W'(1);
                                n_count      = r_count + CW'(1);
                            end
                        end
                        OP_DEQ: begin
                            if (r_count == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_ra = r_idx + AW'(1);
                if (take) begin
                    n_best_idx     = r_idx;
                    n_best_prio    = r_rd_data.prio;
                    n_best_age     = cand_age;
                    n_best_payload = r_rd_data.payload;
                end
                if (last) begin
                    // move the last entry into the slot of the one leaving
                    mem_we        = 1'b1;
                    mem_wa        = take ? r_idx : r_best_idx;
                    mem_wd        = r_rd_data;
                    n_res_payload = take ? r_rd_data.payload : r_best_payload;
                    n_res_valid   = 1'b1;
                    n_res_status  = STAT_OK;
                    n_count       = r_count - CW'(1);
                    n_state       = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {2'b00, (r_count == '0), CNT_OUT_W'(r_count),
                                  r_res_payload};
                    n_m_tuser  = {r_res_status, r_res_valid};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_next_seq <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_next_seq <= n_next_seq;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_best_idx     <= n_best_idx;
        r_best_prio    <= n_best_prio;
        r_best_age     <= n_best_age;
        r_best_payload <= n_best_payload;
        r_res_payload  <= n_res_payload;
        r_res_valid    <= n_res_valid;
        r_res_status   <= n_res_status;
        r_m_tdata      <= n_m_tdata;
        r_m_tuser      <= n_m_tuser;
    end

endmodule

/* bench/tb_stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: self-checking bench for the stable priority queue
// Drives enqueue, dequeue, clear and unused op words through the input
// stream, predicts each result word with a shadow copy of the queue and
// compares every output word field by field, under random stalls on both
// sides except in the last third of the random run.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [31:0] PRIO_MAX = 32'h7fff_ffff;
    localparam logic [31:0] PRIO_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 valid;
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
    } t_result;

    // Shadow copy of the queue plus the words it owes the output stream.
    class queue_shadow;
        t_entry          slots [SPQ_DEPTH];
        int              held;
        logic [SEQ_W-1:0] next_seq;
        t_result         pending [$];
        int              failures;

        function new();
            held     = 0;
            next_seq = '0;
            failures = 0;
        endfunction

        // Higher priority first; on a tie the larger age leaves first.
        function bit leaves_first(int a, int b);
            logic [SEQ_W-1:0] age_a;
            logic [SEQ_W-1:0] age_b;
            if (slots[a].prio != slots[b].prio)
                return slots[a].prio > slots[b].prio;
            age_a = next_seq - slots[a].seq;
            age_b = next_seq - slots[b].seq;
            return age_a > age_b;
        endfunction

        function void accept_request(logic [OP_W-1:0] op, logic [31:0] prio,
                                     logic [31:0] pay);
            t_result r;
            int best;
            r = '{payload: '0, valid: 1'b0, status: STAT_OK, count: '0, empty: 1'b0};
            case (op)
                OP_ENQ: begin
                    if (held >= SPQ_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        slots[held] = '{prio: prio, payload: pay, seq: next_seq};
                        next_seq = next_seq + 1;
                        held++;
                    end
                end
                OP_DEQ: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        best = 0;
                        for (int k = 1; k < held; k++)
                            if (leaves_first(k, best)) best = k;
                        r.payload = slots[best].payload;
                        r.valid   = 1'b1;
                        // fill the hole with the last slot
                        slots[best] = slots[held-1];
                        held--;
                    end
                end
                OP_CLR: begin
                    held = 0;
                end
                default: ;
            endcase
            r.count = held[CNT_OUT_W-1:0];
            r.empty = (held == 0);
            pending.push_back(r);
        endfunction

        function void check_response(logic [39:0] data, logic [2:0] user);
            t_result want;
            bit bad;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: tdata=%h tuser=%h", data, user);
                return;
            end
            want = pending.pop_front();
            bad = (data[31:0] !== want.payload) || (user[0] !== want.valid) ||
                  (user[2:1] !== want.status) || (data[36:32] !== want.count) ||
                  (data[37] !== want.empty) || (data[39:38] !== 2'b00);
            if (bad) begin
                failures++;
                if (failures <= 10)
                    $display("word differs: exp pay=%h vld=%b st=%0d cnt=%0d emp=%b,",
                             want.payload, want.valid, want.status, want.count,
                             want.empty,
                             " got pay=%h vld=%b st=%0d cnt=%0d emp=%b pad=%b",
                             data[31:0], user[0], user[2:1], data[36:32], data[37],
                             data[39:38]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // priority_req[31:0], payload[63:32]
    logic [1:0]  s_axis_tuser = '0;    // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // out_payload[31:0], entry_count[36:32],
                                       // is_empty[37], zero[39:38]
    logic [2:0]  m_axis_tuser;         // out_valid[0], status[2:1]

    int          src_idle_pct = 38;
    int          snk_idle_pct = 56;
    queue_shadow shadow;

    logic [31:0] dir_prio [16] = '{PRIO_MAX, PRIO_MIN, 32'h0, 32'hffff_ffff,
                                   32'd5, 32'd5, 32'd5, 32'd5,
                                   PRIO_MAX, PRIO_MIN, 32'h0, 32'd7,
                                   32'hffff_ffff, 32'd5, 32'd7, PRIO_MAX};

    stable_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [31:0] prio,
                             input logic [31:0] pay);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pay, prio};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.accept_request(op, prio, pay);
    endtask

    task automatic run_directed();
        send_word(OP_DEQ, $urandom, $urandom);
        send_word(OP_UNUSED, $urandom, $urandom);
        // fill with ties at both extremes and in the middle
        for (int i = 0; i < SPQ_DEPTH; i++)
            send_word(OP_ENQ, dir_prio[i], (i == 0) ? 32'h0 :
                      (i == 1) ? 32'hffff_ffff : $urandom);
        send_word(OP_ENQ, PRIO_MAX, 32'hffff_ffff);
        send_word(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_DEQ, 32'h0, 32'h0);
        send_word(OP_DEQ, 32'h0, 32'h0);
        send_word(OP_CLR, $urandom, $urandom);
        send_word(OP_DEQ, $urandom, $urandom);
        send_word(OP_ENQ, PRIO_MIN, $urandom);
        send_word(OP_DEQ, $urandom, $urandom);
    endtask

    task automatic run_random();
        bit          filling;
        int          r;
        logic [1:0]  op;
        logic [31:0] prio;
        logic [31:0] pay;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                src_idle_pct = 56;
                snk_idle_pct = 38;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // swing between filling up and draining so both ends get hit
            if (shadow.held == SPQ_DEPTH && $urandom_range(0, 1)) filling = 1'b0;
            if (shadow.held == 0) filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_CLR;
            else if (r < 4)
                op = OP_UNUSED;
            else
                op = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? OP_ENQ : OP_DEQ;
            r = $urandom_range(0, 9);
            if (r < 5)
                prio = $urandom_range(0, 3) - 2;
            else if (r == 5)
                prio = PRIO_MAX;
            else if (r == 6)
                prio = PRIO_MIN;
            else
                prio = $urandom;
            pay = $urandom;
            send_word(op, prio, pay);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_response(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("stable_priority_queue: mismatch");
        $finish;
    end

    initial begin
        shadow = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.pending.size() == 0) begin
            $display("stable_priority_queue: match");
        end else begin
            $display("stable_priority_queue: mismatch");
        end
        $finish;
    end

endmodule
